// ----- rtl/stbs_pkg.sv -----
// Shared types and constants for the sorted table binary search block.
// Holds the beat payload structs and the controller/datapath command and status structs.
// No dependencies.
package stbs_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;
  localparam int DEF_TABLE_DEPTH = 1024;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef struct packed {
    logic                    op;
    logic [IDX_W-1:0]        entry_index;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
  } out_t;

  typedef struct packed {
    logic wr;
    logic load;
    logic rd;
    logic step;
    logic emit_miss;
    logic emit_hit;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic eq;
  } sts_t;

endpackage

// ----- rtl/stbs_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package dependency.
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/stbs_ctrl.sv -----
// Controller state machine for the binary search: sequences accept, probe and compare.
// Depends on stbs_pkg for the command and status structs.
module stbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          op,
  output logic          busy,
  input  stbs_pkg::sts_t sts,
  output stbs_pkg::cmd_t cmd
);
  import stbs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (op == OP_SEARCH) begin
            cmd.load  = 1'b1;
            state_nxt = ST_PROBE;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (sts.empty) begin
          cmd.emit_miss = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.eq) begin
          cmd.emit_hit = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_PROBE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/stbs_dp.sv -----
// Datapath for the binary search: table RAM, count register, interval bounds and result register.
// Depends on stbs_pkg and stbs_ram.
module stbs_dp #(
  parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stbs_pkg::in_t               in_item,
  input  logic                        cfg_we,
  input  logic [stbs_pkg::CNT_W-1:0]  cfg_wdata,
  input  stbs_pkg::cmd_t              cmd,
  output stbs_pkg::sts_t              sts,
  output logic                        out_valid,
  output stbs_pkg::out_t              out_item
);
  import stbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  // Signed bound width: holds 0..TABLE_DEPTH and -1.
  localparam int BW = $clog2(TABLE_DEPTH + 1) + 1;

  logic [CNT_W-1:0]        count_r;
  logic signed [BW-1:0]    lo_r;
  logic signed [BW-1:0]    hi_r;
  logic signed [VAL_W-1:0] target_r;
  logic [AW-1:0]           mid_r;
  logic                    out_valid_r;
  out_t                    out_item_r;

  logic [BW-1:0]           cnt_sat;
  logic signed [BW:0]      bound_sum;
  logic [AW-1:0]           mid_c;
  logic [VAL_W-1:0]        rd_data;
  logic                    wr_ok;
  logic                    lt;

  always_comb begin
    if (32'(count_r) > 32'(TABLE_DEPTH)) begin
      cnt_sat = BW'(TABLE_DEPTH);
    end else begin
      cnt_sat = BW'(count_r);
    end
  end

  // Both bounds are non-negative whenever a probe is issued, so the midpoint
  // is simply the halved sum.
  assign bound_sum = {lo_r[BW-1], lo_r} + {hi_r[BW-1], hi_r};
  assign mid_c     = bound_sum[AW:1];

  assign wr_ok = cmd.wr && (32'(in_item.entry_index) < 32'(TABLE_DEPTH));

  stbs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (AW'(in_item.entry_index)),
    .wdata (in_item.value),
    .re    (cmd.rd),
    .raddr (mid_c),
    .rdata (rd_data)
  );

  assign lt        = $signed(rd_data) < target_r;
  assign sts.empty = lo_r > hi_r;
  assign sts.eq    = ($signed(rd_data) == target_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      lo_r        <= '0;
      hi_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (cmd.load) begin
        lo_r <= '0;
        hi_r <= $signed(cnt_sat) - BW'(1);
      end else if (cmd.step) begin
        if (lt) begin
          lo_r <= $signed(BW'(mid_r)) + BW'(1);
        end else begin
          hi_r <= $signed(BW'(mid_r)) - BW'(1);
        end
      end
      out_valid_r <= cmd.emit_hit || cmd.emit_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target_r <= in_item.value;
    end
    if (cmd.rd) begin
      mid_r <= mid_c;
    end
    if (cmd.emit_hit || cmd.emit_miss) begin
      out_item_r.found       <= cmd.emit_hit;
      out_item_r.match_index <= cmd.emit_hit ? IDX_W'(mid_r) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/sorted_table_binary_search.sv -----
// Sorted table binary search, top level: the controller and the datapath joined.
// Depends on stbs_pkg, stbs_ctrl, stbs_dp and stbs_ram.
//
// A beat is taken when start is high and busy is low. A write beat stores value at
// entry_index and leaves busy low, so writes can follow back to back. A search beat
// runs a closed-interval binary search over the first entry_count entries. Each probe
// issues the registered table read in the probe state and then compares in the
// compare state; busy stays high until the search hits or the interval is empty.
// The result appears on out_item for exactly one cycle, marked by out_valid, in the
// first cycle that busy is low again; the receiver cannot stall it and must take it
// then. The user must write entry count through cfg_we and cfg_wdata only while the
// block is idle; the block itself does not enforce it.
module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::DEF_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  stbs_pkg::in_t              in_item,
  input  logic                       cfg_we,
  input  logic [stbs_pkg::CNT_W-1:0] cfg_wdata,
  output logic                       out_valid,
  output stbs_pkg::out_t             out_item
);
  import stbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  stbs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_item.op),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // A result always lands once the controller is back at rest.
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a search is still running");

  // Two results never come in consecutive cycles.
  a_no_double_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe repeated");

  // A write beat never causes a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.op == OP_WRITE)) |=> !out_valid)
    else $error("result after a write beat");

  // A miss reports index zero.
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.found) |-> (out_item.match_index == '0))
    else $error("nonzero index on a miss");

endmodule

// ----- sim/sorted_table_binary_search_tb.sv -----
// Self-checking testbench for sorted_table_binary_search: directed and random write and
// search beats, checked against a local binary search predictor held in a scoreboard class.
// Depends on stbs_pkg and the sorted_table_binary_search RTL.
module sorted_table_binary_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stbs_pkg::*;

  localparam int DEPTH          = DEF_TABLE_DEPTH;
  localparam int IDLE_NONE      = 0;
  localparam int IDLE_HEAVY     = 81;
  localparam int IDLE_LIGHT     = 34;
  localparam int SETTLE_CYCLES  = 30;
  localparam int RANDOM_ITEMS   = 1900;
  localparam int OPS_PER_PHASE  = 80;
  // Searches are bounded and sender gaps at 81 percent idling are geometric, so this
  // limit leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 2000;

  class search_scoreboard;
    logic signed [VAL_W-1:0] entries [DEPTH];
    int unsigned             entry_count;
    out_t                    pending_matches [$];
    int                      errors;

    function new();
      entry_count = 0;
      errors      = 0;
    endfunction

    function void set_count(logic [CNT_W-1:0] c);
      entry_count = 32'(c);
    endfunction

    function int pending();
      return pending_matches.size();
    endfunction

    // Writes update the local table; searches run the same closed-interval probe
    // sequence as the block and queue the result it must produce.
    function void note_beat(in_t b);
      int                      lo, hi, mid, n;
      logic signed [VAL_W-1:0] target;
      out_t                    r;
      if (b.op == OP_WRITE) begin
        entries[b.entry_index] = b.value;
        return;
      end
      n      = (entry_count > DEPTH) ? DEPTH : entry_count;
      target = $signed(b.value);
      r      = '0;
      lo     = 0;
      hi     = n - 1;
      while (!r.found && lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (entries[mid] == target) begin
          r.found       = 1'b1;
          r.match_index = IDX_W'(mid);
        end else if (entries[mid] < target) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
      pending_matches.push_back(r);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (pending_matches.size() == 0) begin
        $error("unexpected result beat: found=%0d match_index=%0d",
               got.found, got.match_index);
        errors++;
        return;
      end
      want = pending_matches.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, actual %0d", want.found, got.found);
        errors++;
      end
      if (got.match_index !== want.match_index) begin
        $error("match_index: expected %0d, actual %0d", want.match_index, got.match_index);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_t              in_item;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;
  logic             out_valid;
  out_t             out_item;

  search_scoreboard        sb = new();
  logic signed [VAL_W-1:0] stim_vals [DEPTH];
  int                      idle_pct;
  int                      items_sent;
  int                      quiet_cycles;

  sorted_table_binary_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_result(out_item);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Start stays high from one beat to the next unless an idle gap is drawn.
  task automatic send_beat(input in_t b);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    in_item <= b;
    do @(posedge clk); while (busy);
    sb.note_beat(b);
    items_sent++;
  endtask

  task automatic send_write(input int idx, input logic signed [VAL_W-1:0] v);
    in_t b;
    b.op          = OP_WRITE;
    b.entry_index = IDX_W'(idx);
    b.value       = v;
    stim_vals[idx] = v;
    send_beat(b);
  endtask

  task automatic send_search(input logic signed [VAL_W-1:0] v);
    in_t b;
    b.op          = OP_SEARCH;
    b.entry_index = IDX_W'($urandom);
    b.value       = v;
    send_beat(b);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] c);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    sb.set_count(c);
    cfg_we <= 1'b0;
  endtask

  // Fills entries 0..n-1 in non-decreasing order. Each step is bounded by the remaining
  // headroom divided by the remaining entries, so the sequence never wraps.
  task automatic fill_sorted(input int n);
    longint cur, room, step;
    cur = -64'sd2147483648;
    if ($urandom_range(3) != 0) cur += longint'($urandom_range(32'h7FFF_FFFF, 0));
    for (int i = 0; i < n; i++) begin
      send_write(i, VAL_W'(cur));
      room = (64'sd2147483647 - cur) / (n - i);
      if ($urandom_range(3) == 0) step = longint'($urandom_range(2, 0));
      else step = longint'($urandom_range(32'(room), 0));
      cur += (step > room) ? room : step;
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_target(input int n);
    int r;
    r = $urandom_range(99);
    if (n > 0 && r < 55) return stim_vals[$urandom_range(n - 1, 0)];
    if (n > 0 && r < 75) return stim_vals[$urandom_range(n - 1, 0)] + (r[0] ? 1 : -1);
    if (r < 85) return r[0] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom;
  endfunction

  // Mostly searches over the filled prefix; some writes land past it and a few
  // land anywhere in the table, which can leave the table out of order.
  task automatic random_op(input int n);
    int r;
    r = $urandom_range(99);
    if (r < 80) send_search(pick_target(n));
    else if (r < 95 && n < DEPTH) send_write($urandom_range(DEPTH - 1, n), $urandom);
    else send_write($urandom_range(DEPTH - 1, 0), $urandom);
  endtask

  task automatic run_phase(input int k);
    logic [CNT_W-1:0] c;
    int               n;
    case (k)
      1: c = 1;
      2: c = CNT_W'(DEPTH);
      3: c = '1;
      4: c = 0;
      default: c = CNT_W'($urandom_range(48, 2));
    endcase
    case (k % 3)
      0: idle_pct = IDLE_NONE;
      1: idle_pct = IDLE_HEAVY;
      default: idle_pct = IDLE_LIGHT;
    endcase
    write_count(c);
    n = (int'(c) > DEPTH) ? DEPTH : int'(c);
    // The saturated-count phase searches the full table left by the phase before it.
    if (k != 3 && n > 0) fill_sorted(n);
    repeat (OPS_PER_PHASE) random_op(n);
  endtask

  initial begin
    int phase;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    idle_pct   = IDLE_NONE;
    items_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With a count of zero the interval is empty before any probe.
    send_search(32'sd0);

    send_write(0, 32'sh8000_0000);
    send_write(1, -32'sd1000);
    send_write(2, -32'sd1);
    send_write(3, 32'sd0);
    send_write(4, 32'sd0);
    send_write(5, 32'sd5);
    send_write(6, 32'sd1000);
    send_write(7, 32'sh7FFF_FFFF);
    send_write(DEPTH - 1, 32'sh5555_AAAA);
    write_count(8);
    send_search(32'sh8000_0000);
    send_search(32'sh7FFF_FFFF);
    send_search(32'sd0);
    send_search(32'sd5);
    send_search(-32'sd1000);
    send_search(-32'sd2);
    send_search(32'sh8000_0001);
    send_search(32'sh7FFF_FFFE);
    // An out-of-order entry can steer the probes away from a value that is present.
    send_write(2, 32'sd99999);
    send_search(32'sd5);
    send_search(32'sd99999);

    items_sent = 0;
    phase      = 0;
    while (phase < 5 || items_sent < RANDOM_ITEMS) begin
      run_phase(phase);
      phase++;
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/stbs_ctrl.sv
rtl/stbs_dp.sv
rtl/sorted_table_binary_search.sv
sim/sorted_table_binary_search_tb.sv
